[design/sorted_timeout_queue_macros.svh]
// assertion macros for the sorted timeout queue
`ifndef SORTED_TIMEOUT_QUEUE_MACROS_SVH
`define SORTED_TIMEOUT_QUEUE_MACROS_SVH

// expression must hold at every clock edge out of reset
`define STQ_ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (expr)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define STQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) else $error(msg);

`endif

[design/stq_pkg.sv]
// types and constants shared by the sorted timeout queue
`timescale 1ns / 1ps

package stq_pkg;

    localparam int DEPTH       = 16;
    localparam int HANDLE_BITS = 8;
    localparam int TIME_W      = 64;
    localparam int FIRE_MAX    = 16;

    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int FIRE_W = $clog2(FIRE_MAX + 1);

    typedef enum logic [1:0] {
        OP_SET    = 2'd0,
        OP_REMOVE = 2'd1,
        OP_TICK   = 2'd2,
        OP_CLEAR  = 2'd3
    } op_t;

    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_FULL    = 2'd1;
    localparam logic [1:0] STAT_MISSING = 2'd2;
    localparam logic [1:0] STAT_CLEARED = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FIND,
        ST_DEL,
        ST_INS,
        ST_TCHK,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic [TIME_W-1:0]      deadline;
        logic [HANDLE_BITS-1:0] handle;
    } entry_t;

endpackage

[design/sorted_timeout_queue.sv]
// sorted timeout queue: deadline-ordered table in one memory, walked per command
//
//  channel | dir | tdata (low bit up)                    | tuser (low bit up)
//  s_      | in  | timer_handle[7:0], delay_ms[39:8]     | opcode[1:0]
//  m_      | out | fired_handle[7:0], head_changed[8],   | status[1:0], fired_valid[2]
//          |     | pending_count[13:9], zero pad         | tlast = last_result
//
// set and remove: accept, then scan the table for the handle; on a hit, pull later entries
// down to close the gap; set then shifts later-deadline entries up from the tail and writes
// the new entry (straight into slot zero of an empty table); the result is loaded last
// clear goes straight to its result; a tick advances time, then removes and reports each due head
// reset clears the time counter, the entry count and the output valid flag
// a stalled result holds the walk; the next item is taken once the walk ends
`timescale 1ns / 1ps
`include "sorted_timeout_queue_macros.svh"

module sorted_timeout_queue (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // timer_handle[7:0], delay_ms[39:8]
    input  logic [1:0]  s_tuser,   // opcode[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // fired_handle[7:0], head_changed[8], pending_count[13:9]
    output logic [2:0]  m_tuser,   // status[1:0], fired_valid[2]
    output logic        m_tlast
);
    import stq_pkg::*;

    state_t                 state_reg, state_next;
    op_t                    op_reg, op_next;
    logic [HANDLE_BITS-1:0] h_reg, h_next;
    logic [TIME_W-1:0]      dl_reg, dl_next;
    logic [TIME_W-1:0]      now_reg, now_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic [CNT_W-1:0]       ptr_reg, ptr_next;
    logic                   pend_reg, pend_next;
    logic                   had_reg, had_next;
    logic [TIME_W-1:0]      old_reg, old_next;
    logic [1:0]             st_reg, st_next;
    logic                   fire_reg, fire_next;
    logic [FIRE_W-1:0]      fire_cnt_reg, fire_cnt_next;
    logic [HANDLE_BITS-1:0] fh_reg, fh_next;
    entry_t                 head_reg;

    logic                   m_tvalid_reg, m_tvalid_next;
    logic [1:0]             m_status_reg, m_status_next;
    logic                   m_fv_reg, m_fv_next;
    logic [7:0]             m_fh_reg, m_fh_next;
    logic                   m_hc_reg, m_hc_next;
    logic [4:0]             m_pend_reg, m_pend_next;
    logic                   m_last_reg, m_last_next;

    // table memory
    entry_t                 mem [DEPTH];
    entry_t                 rd_reg;
    logic                   mem_we;
    logic [ADDR_W-1:0]      mem_wa;
    logic [ADDR_W-1:0]      mem_ra;
    entry_t                 mem_wd;

    logic                   in_acc;
    op_t                    in_op;
    logic                   find_hit, find_miss;
    logic [CNT_W:0]         del_weff, del_rd;
    logic                   del_done;
    logic                   ins_shift, ins_done;
    logic [CNT_W-1:0]       ptr_m1, ptr_m2;
    logic                   fire_ok, emit_load, emit_more, head_chg;
    entry_t                 new_entry;

    assign s_tready  = (state_reg == ST_IDLE);
    assign in_acc    = s_tvalid && s_tready;
    assign in_op     = op_t'(s_tuser);

    assign find_hit  = pend_reg && (rd_reg.handle == h_reg);
    assign find_miss = !find_hit && (ptr_reg == cnt_reg);

    // rd_reg holds the entry after the write pointer once a read is pending
    assign del_weff  = pend_reg ? ({1'b0, ptr_reg} + 1'b1) : {1'b0, ptr_reg};
    assign del_rd    = del_weff + 1'b1;
    assign del_done  = !(del_rd < {1'b0, cnt_reg});

    assign ptr_m1    = ptr_reg - 1'b1;
    assign ptr_m2    = ptr_reg - CNT_W'(2);
    assign ins_shift = pend_reg && (rd_reg.deadline > dl_reg);
    assign ins_done  = (pend_reg && !ins_shift) || (!pend_reg && (ptr_reg == '0));
    assign new_entry = '{deadline: dl_reg, handle: h_reg};

    assign fire_ok   = (cnt_reg != '0) && (head_reg.deadline <= now_reg);
    assign emit_load = !m_tvalid_reg || m_tready;
    assign emit_more = fire_reg && (fire_cnt_reg < FIRE_W'(FIRE_MAX - 1)) && fire_ok;
    assign head_chg  = (had_reg != (cnt_reg != '0)) ||
                       (had_reg && (head_reg.deadline != old_reg));

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_acc) begin
                    unique case (in_op)
                        OP_SET, OP_REMOVE: state_next = ST_FIND;
                        OP_TICK:           state_next = ST_TCHK;
                        OP_CLEAR:          state_next = ST_EMIT;
                    endcase
                end
            end
            ST_FIND: begin
                if (find_hit) begin
                    state_next = ST_DEL;
                end else if (find_miss) begin
                    if (op_reg == OP_SET && cnt_reg < CNT_W'(DEPTH)) begin
                        state_next = ST_INS;
                    end else begin
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_DEL: begin
                if (del_done) begin
                    state_next = (op_reg == OP_SET) ? ST_INS : ST_EMIT;
                end
            end
            ST_INS: begin
                if (ins_done) begin
                    state_next = ST_EMIT;
                end
            end
            ST_TCHK: begin
                state_next = fire_ok ? ST_DEL : ST_EMIT;
            end
            ST_EMIT: begin
                if (emit_load) begin
                    state_next = emit_more ? ST_DEL : ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb begin
        op_next       = op_reg;
        h_next        = h_reg;
        dl_next       = dl_reg;
        now_next      = now_reg;
        cnt_next      = cnt_reg;
        ptr_next      = ptr_reg;
        pend_next     = pend_reg;
        had_next      = had_reg;
        old_next      = old_reg;
        st_next       = st_reg;
        fire_next     = fire_reg;
        fire_cnt_next = fire_cnt_reg;
        fh_next       = fh_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_status_next = m_status_reg;
        m_fv_next     = m_fv_reg;
        m_fh_next     = m_fh_reg;
        m_hc_next     = m_hc_reg;
        m_pend_next   = m_pend_reg;
        m_last_next   = m_last_reg;
        mem_we        = 1'b0;
        mem_wa        = ptr_reg[ADDR_W-1:0];
        mem_wd        = rd_reg;
        mem_ra        = ptr_reg[ADDR_W-1:0];

        unique case (state_reg)
            ST_IDLE: begin
                if (in_acc) begin
                    op_next       = in_op;
                    h_next        = HANDLE_BITS'(s_tdata[7:0]);
                    dl_next       = now_reg + {32'd0, s_tdata[39:8]};
                    had_next      = (cnt_reg != '0);
                    old_next      = head_reg.deadline;
                    ptr_next      = '0;
                    pend_next     = 1'b0;
                    st_next       = STAT_OK;
                    fire_next     = 1'b0;
                    fire_cnt_next = '0;
                    if (in_op == OP_TICK) begin
                        now_next = now_reg + 1'b1;
                    end
                    if (in_op == OP_CLEAR) begin
                        cnt_next = '0;
                        st_next  = STAT_CLEARED;
                    end
                end
            end
            ST_FIND: begin
                if (find_hit) begin
                    ptr_next  = ptr_m1;
                    pend_next = 1'b0;
                end else if (find_miss) begin
                    pend_next = 1'b0;
                    if (op_reg == OP_SET) begin
                        if (cnt_reg >= CNT_W'(DEPTH)) begin
                            st_next = STAT_FULL;
                        end
                        ptr_next = cnt_reg;
                    end else begin
                        st_next = STAT_MISSING;
                    end
                end else begin
                    mem_ra    = ptr_reg[ADDR_W-1:0];
                    ptr_next  = ptr_reg + 1'b1;
                    pend_next = 1'b1;
                end
            end
            ST_DEL: begin
                // pull each later entry down by one
                if (pend_reg) begin
                    mem_we   = 1'b1;
                    mem_wa   = ptr_reg[ADDR_W-1:0];
                    mem_wd   = rd_reg;
                    ptr_next = ptr_reg + 1'b1;
                end
                if (!del_done) begin
                    mem_ra    = del_rd[ADDR_W-1:0];
                    pend_next = 1'b1;
                end else begin
                    pend_next = 1'b0;
                    cnt_next  = cnt_reg - 1'b1;
                    ptr_next  = cnt_reg - 1'b1;
                end
            end
            ST_INS: begin
                // walk down from the tail, moving later deadlines up by one
                if (pend_reg) begin
                    mem_we = 1'b1;
                    mem_wa = ptr_reg[ADDR_W-1:0];
                    if (ins_shift) begin
                        mem_wd   = rd_reg;
                        ptr_next = ptr_m1;
                        if (ptr_m1 != '0) begin
                            mem_ra    = ptr_m2[ADDR_W-1:0];
                            pend_next = 1'b1;
                        end else begin
                            pend_next = 1'b0;
                        end
                    end else begin
                        mem_wd    = new_entry;
                        pend_next = 1'b0;
                        cnt_next  = cnt_reg + 1'b1;
                    end
                end else if (ptr_reg == '0) begin
                    mem_we   = 1'b1;
                    mem_wa   = '0;
                    mem_wd   = new_entry;
                    cnt_next = cnt_reg + 1'b1;
                end else begin
                    mem_ra    = ptr_m1[ADDR_W-1:0];
                    pend_next = 1'b1;
                end
            end
            ST_TCHK: begin
                if (fire_ok) begin
                    had_next  = 1'b1;
                    old_next  = head_reg.deadline;
                    fh_next   = head_reg.handle;
                    fire_next = 1'b1;
                    ptr_next  = '0;
                    pend_next = 1'b0;
                end
            end
            ST_EMIT: begin
                if (emit_load) begin
                    m_tvalid_next = 1'b1;
                    m_status_next = st_reg;
                    m_fv_next     = fire_reg;
                    m_fh_next     = fire_reg ? 8'(fh_reg) : 8'd0;
                    m_hc_next     = head_chg;
                    m_pend_next   = 5'(cnt_reg);
                    m_last_next   = !emit_more;
                    if (fire_reg) begin
                        fire_cnt_next = fire_cnt_reg + 1'b1;
                    end
                    if (emit_more) begin
                        had_next  = 1'b1;
                        old_next  = head_reg.deadline;
                        fh_next   = head_reg.handle;
                        ptr_next  = '0;
                        pend_next = 1'b0;
                    end
                end
            end
            default: begin
                pend_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        rd_reg <= mem[mem_ra];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            now_reg      <= '0;
            cnt_reg      <= '0;
            pend_reg     <= 1'b0;
            fire_reg     <= 1'b0;
            fire_cnt_reg <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            now_reg      <= now_next;
            cnt_reg      <= cnt_next;
            pend_reg     <= pend_next;
            fire_reg     <= fire_next;
            fire_cnt_reg <= fire_cnt_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg       <= op_next;
        h_reg        <= h_next;
        dl_reg       <= dl_next;
        ptr_reg      <= ptr_next;
        had_reg      <= had_next;
        old_reg      <= old_next;
        st_reg       <= st_next;
        fh_reg       <= fh_next;
        m_status_reg <= m_status_next;
        m_fv_reg     <= m_fv_next;
        m_fh_reg     <= m_fh_next;
        m_hc_reg     <= m_hc_next;
        m_pend_reg   <= m_pend_next;
        m_last_reg   <= m_last_next;
        // copy of entry zero, kept in step with every write there
        if (mem_we && (mem_wa == '0)) begin
            head_reg <= mem_wd;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {2'b00, m_pend_reg, m_hc_reg, m_fh_reg};
    assign m_tuser  = {m_fv_reg, m_status_reg};
    assign m_tlast  = m_last_reg;

    `STQ_ASSERT_ALWAYS(a_cnt_range, cnt_reg <= CNT_W'(DEPTH), "entry count above depth")
    `STQ_ASSERT_ALWAYS(a_wr_live, !mem_we || (CNT_W'(mem_wa) <= cnt_reg), "write past tail")
    `STQ_ASSERT_NEXT(a_accept_busy, s_tvalid && s_tready, !s_tready, "item taken while busy")
    `STQ_ASSERT_ALWAYS(a_fire_ok, !(m_tvalid_reg && m_fv_reg) || (m_status_reg == STAT_OK), "bad fire")

endmodule
